### hw/rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg: shared definitions for the free list block allocator
// Operation and status codes, default pool size, and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int DEF_MAX_BLOCKS = 1024;
    localparam int STATUS_W       = 2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic rebuild;    // block_count written: restart the link sweep
        logic sweep;      // write one link entry of the rebuild sweep
        logic accept;     // request word taken this cycle
        logic load_head;  // pop state: head loaded from link memory
    } t_fla_cmd;

    typedef struct packed {
        logic sweep_last; // sweep is at the last link entry
        logic skid_full;  // no room for another response word
        logic pop_start;  // presented word is an allocate on a non-empty list
    } t_fla_stat;

endpackage

### hw/rtl/fla_if.sv
// ----------------------------------------------------------------------------
// fla_req_if / fla_rsp_if: request and response channels
// Valid/ready channels; a word moves on a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface fla_req_if #(
    parameter int IDX_W = 10
);
    logic             valid;
    logic             ready;
    logic             operation;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output operation, output block_index, input ready);
    modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface fla_rsp_if #(
    parameter int IDX_W = 10,
    parameter int CNT_W = 11
);
    logic                         valid;
    logic                         ready;
    logic [IDX_W-1:0]             granted_index;
    logic [fla_pkg::STATUS_W-1:0] status;
    logic [CNT_W-1:0]             free_blocks;

    modport source (output valid, output granted_index, output status,
                    output free_blocks, input ready);
    modport sink   (input valid, input granted_index, input status,
                    input free_blocks, output ready);
endinterface

### hw/rtl/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl: allocator controller
// Sequences the link rebuild sweep, request acceptance and the pop cycle.
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_req_valid,
    input  fla_pkg::t_fla_stat i_stat,
    output logic              o_req_ready,
    output fla_pkg::t_fla_cmd  o_cmd
);

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_POP   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_req_ready = (r_state == S_IDLE) && !i_stat.skid_full;
    assign accept      = o_req_ready && i_req_valid;

    always_comb begin
        o_cmd.rebuild   = i_cfg_we;
        o_cmd.sweep     = (r_state == S_SWEEP) && !i_cfg_we;
        o_cmd.accept    = accept;
        o_cmd.load_head = (r_state == S_POP);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: if (i_stat.sweep_last) n_state = S_IDLE;
            S_IDLE:  if (accept && i_stat.pop_start) n_state = S_POP;
            S_POP:   n_state = S_IDLE;
            default: n_state = S_SWEEP;
        endcase
        if (i_cfg_we) n_state = S_SWEEP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/fla_datapath.sv
// ----------------------------------------------------------------------------
// fla_datapath: allocator datapath
// Link memory, list head, free count, block_count register and the
// two-word response buffer.
// ----------------------------------------------------------------------------
module fla_datapath #(
    parameter int MAX_BLOCKS = fla_pkg::DEF_MAX_BLOCKS,
    parameter int IDX_W      = $clog2(MAX_BLOCKS),
    parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CNT_W-1:0]             i_cfg_data,
    input  fla_pkg::t_fla_cmd            i_cmd,
    input  logic                         i_operation,
    input  logic [IDX_W-1:0]             i_block_index,
    input  logic                         i_rsp_ready,
    output fla_pkg::t_fla_stat           o_stat,
    output logic                         o_rsp_valid,
    output logic [IDX_W-1:0]             o_granted_index,
    output logic [fla_pkg::STATUS_W-1:0] o_status,
    output logic [CNT_W-1:0]             o_free_blocks
);

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    logic [IDX_W-1:0] mem [MAX_BLOCKS];
    logic [IDX_W-1:0] r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [IDX_W-1:0] mem_wdata;

    logic [CNT_W-1:0] r_block_count;
    logic [IDX_W-1:0] r_head;
    logic             r_head_valid;
    logic [CNT_W-1:0] r_free_total;
    logic [IDX_W-1:0] r_sweep_idx;

    logic [CNT_W-1:0] n_block_count;
    logic [IDX_W-1:0] n_head;
    logic             n_head_valid;
    logic [CNT_W-1:0] n_free_total;
    logic [IDX_W-1:0] n_sweep_idx;

    logic                         r_out_valid;
    logic [IDX_W-1:0]             r_out_grant;
    logic [fla_pkg::STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]             r_out_free;
    logic                         r_skid_valid;
    logic [IDX_W-1:0]             r_skid_grant;
    logic [fla_pkg::STATUS_W-1:0] r_skid_status;
    logic [CNT_W-1:0]             r_skid_free;
    logic                         n_out_valid;
    logic [IDX_W-1:0]             n_out_grant;
    logic [fla_pkg::STATUS_W-1:0] n_out_status;
    logic [CNT_W-1:0]             n_out_free;
    logic                         n_skid_valid;
    logic [IDX_W-1:0]             n_skid_grant;
    logic [fla_pkg::STATUS_W-1:0] n_skid_status;
    logic [CNT_W-1:0]             n_skid_free;

    logic                         is_alloc;
    logic                         rel_ok;
    logic                         sweep_last;
    logic [CNT_W-1:0]             cfg_sat;
    logic [CNT_W-1:0]             free_dec;
    logic [IDX_W-1:0]             res_grant;
    logic [fla_pkg::STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]             res_free;
    logic                         take;

    assign is_alloc   = (i_operation == fla_pkg::OP_ALLOC);
    assign rel_ok     = (CNT_W'(i_block_index) < r_block_count);
    assign sweep_last = (r_sweep_idx == LAST_IDX);
    assign free_dec   = (r_free_total != '0) ? r_free_total - 1'b1 : r_free_total;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_sat = CNT_W'(1);
        end else if (i_cfg_data > MAX_CNT) begin
            cfg_sat = MAX_CNT;
        end else begin
            cfg_sat = i_cfg_data;
        end
    end

    assign o_stat.sweep_last = sweep_last;
    assign o_stat.skid_full  = r_skid_valid;
    assign o_stat.pop_start  = r_head_valid && is_alloc;

    // result of the presented word, plus the single link memory access
    always_comb begin
        res_grant  = '0;
        res_status = fla_pkg::ST_OK;
        res_free   = r_free_total;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_free_total = r_free_total;
        n_block_count = r_block_count;
        n_sweep_idx  = r_sweep_idx;
        mem_we    = 1'b0;
        mem_addr  = r_head;
        mem_wdata = r_head;

        if (i_cmd.sweep) begin
            mem_we      = 1'b1;
            mem_addr    = r_sweep_idx;
            mem_wdata   = sweep_last ? '0 : r_sweep_idx + 1'b1;
            n_sweep_idx = sweep_last ? r_sweep_idx : r_sweep_idx + 1'b1;
        end

        if (i_cmd.load_head) begin
            n_head = r_rdata;
        end

        if (is_alloc) begin
            if (r_head_valid) begin
                res_grant = r_head;
                res_free  = free_dec;
            end else begin
                res_status = fla_pkg::ST_EXHAUSTED;
            end
        end else begin
            // the sweep owns the memory port while it runs
            if (!i_cmd.sweep) begin
                mem_addr = i_block_index;
            end
            if (rel_ok) begin
                res_free = (r_free_total == MAX_CNT) ? r_free_total
                                                     : r_free_total + 1'b1;
            end else begin
                res_status = fla_pkg::ST_BAD_INDEX;
            end
        end

        if (i_cmd.accept) begin
            if (is_alloc) begin
                if (r_head_valid) begin
                    n_free_total = free_dec;
                    n_head_valid = (free_dec != '0);
                end
            end else if (rel_ok) begin
                mem_we       = 1'b1;
                mem_wdata    = r_head;
                n_head       = i_block_index;
                n_head_valid = 1'b1;
                n_free_total = res_free;
            end
        end

        if (i_cmd.rebuild) begin
            n_block_count = cfg_sat;
            n_head        = '0;
            n_head_valid  = 1'b1;
            n_free_total  = cfg_sat;
            n_sweep_idx   = '0;
            mem_we        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    // response buffer: output word plus one skid word
    assign take = r_out_valid && i_rsp_ready;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_grant   = r_out_grant;
        n_out_status  = r_out_status;
        n_out_free    = r_out_free;
        n_skid_valid  = r_skid_valid;
        n_skid_grant  = r_skid_grant;
        n_skid_status = r_skid_status;
        n_skid_free   = r_skid_free;
        if (take) begin
            n_out_valid  = r_skid_valid;
            n_out_grant  = r_skid_grant;
            n_out_status = r_skid_status;
            n_out_free   = r_skid_free;
            n_skid_valid = 1'b0;
        end
        if (i_cmd.accept) begin
            if (!n_out_valid) begin
                n_out_valid  = 1'b1;
                n_out_grant  = res_grant;
                n_out_status = res_status;
                n_out_free   = res_free;
            end else begin
                n_skid_valid  = 1'b1;
                n_skid_grant  = res_grant;
                n_skid_status = res_status;
                n_skid_free   = res_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= MAX_CNT;
            r_head        <= '0;
            r_head_valid  <= 1'b1;
            r_free_total  <= MAX_CNT;
            r_sweep_idx   <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_block_count <= n_block_count;
            r_head        <= n_head;
            r_head_valid  <= n_head_valid;
            r_free_total  <= n_free_total;
            r_sweep_idx   <= n_sweep_idx;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_grant   <= n_out_grant;
        r_out_status  <= n_out_status;
        r_out_free    <= n_out_free;
        r_skid_grant  <= n_skid_grant;
        r_skid_status <= n_skid_status;
        r_skid_free   <= n_skid_free;
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_granted_index = r_out_grant;
    assign o_status        = r_out_status;
    assign o_free_blocks   = r_out_free;

endmodule

### hw/rtl/free_list_block_allocator.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator: LIFO free-list pool allocator
// Hands out and takes back block indices of a fixed pool of equal blocks.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request word: operation (0 allocate, 1 release) and
//   block_index (release only). o_rsp returns one word per request:
//   granted_index, status (ok / pool exhausted / bad index) and free_blocks.
//   i_cfg_we with i_cfg_data writes block_count (0 reads as 1, values above
//   MAX_BLOCKS saturate); the write rebuilds the free list 0,1,...,count-1.
//   Write it only with no request in flight.
// Timing:
//   The response is registered; while the output word is held, it waits in
//   the skid word. An allocate that grants a block is followed by a pop
//   state with i_req.ready low, since the new list head comes from the link
//   memory, whose read port is registered. Releases, exhausted allocates and bad releases need no pop state.
// Reset and rebuild:
//   After reset, and after every block_count write, the link memory is swept
//   one entry a cycle, every entry in turn, with i_req.ready low.
// Stall:
//   A two-word response buffer lets one more request be taken while the
//   receiver holds o_rsp.ready low; after that i_req.ready drops.
// ----------------------------------------------------------------------------
module free_list_block_allocator #(
    parameter int MAX_BLOCKS = fla_pkg::DEF_MAX_BLOCKS,
    parameter int IDX_W      = $clog2(MAX_BLOCKS),
    parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    fla_req_if.sink          i_req,
    fla_rsp_if.source        o_rsp
);

    fla_pkg::t_fla_cmd  cmd;
    fla_pkg::t_fla_stat stat;

    fla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    fla_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_operation     (i_req.operation),
        .i_block_index   (i_req.block_index),
        .i_rsp_ready     (o_rsp.ready),
        .o_stat          (stat),
        .o_rsp_valid     (o_rsp.valid),
        .o_granted_index (o_rsp.granted_index),
        .o_status        (o_rsp.status),
        .o_free_blocks   (o_rsp.free_blocks)
    );

    // no request is taken while the link memory is being rebuilt
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> !i_req.ready)
        else $error("request taken during link sweep");

    // in the cycle after a pop is taken, i_req.ready is low
    a_pop_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && stat.pop_start) |=> !i_req.ready)
        else $error("request taken during pop cycle");

    // a block_count write always restarts the sweep
    a_cfg_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> cmd.sweep)
        else $error("config write did not start rebuild");

    // exhausted only when no block is free, and no index granted then
    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == fla_pkg::ST_EXHAUSTED)
            |-> (o_rsp.free_blocks == '0 && o_rsp.granted_index == '0))
        else $error("exhausted response inconsistent");

endmodule

### sim/free_list_block_allocator_test.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator_test: self-checking bench for the pool allocator
// A shadow free list predicts every response word. Directed requests cover the
// reset pool, a single-block pool, register saturation, double frees and one long
// receiver hold-off that fills the response path. Random request mixes then run
// over several pool sizes with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module free_list_block_allocator_test;

    localparam int POOL_MAX      = fla_pkg::DEF_MAX_BLOCKS;
    localparam int IDX_W         = 10;
    localparam int CNT_W         = 11;
    localparam int IDLE_LIMIT    = 10000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [IDX_W-1:0]             granted_index;
        logic [fla_pkg::STATUS_W-1:0] status;
        logic [CNT_W-1:0]             free_blocks;
    } t_pool_reply;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    fla_req_if #(.IDX_W(IDX_W)) req_if ();
    fla_rsp_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) rsp_if ();

    free_list_block_allocator #(
        .MAX_BLOCKS(POOL_MAX)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if),
        .o_rsp     (rsp_if)
    );

    // shadow copy of the free list
    logic [IDX_W-1:0] link_mem [POOL_MAX];
    logic [IDX_W-1:0] head_idx;
    logic             head_ok;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] pool_size;

    t_pool_reply replies_due[$];
    int          held_blocks[$];   // indices the stimulus believes are handed out

    int fail_count      = 0;
    int reported        = 0;
    int req_count       = 0;
    int grant_count     = 0;
    int exhausted_count = 0;
    int bad_index_count = 0;
    int release_count   = 0;
    int size_count      = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int holdoff_len     = 0;
    bit no_gaps         = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] clamp_pool_size(logic [CNT_W-1:0] v);
        if (v == 0)
            return CNT_W'(1);
        if (v > POOL_MAX)
            return CNT_W'(POOL_MAX);
        return v;
    endfunction

    function automatic void rebuild_list();
        for (int i = 0; i < POOL_MAX; i++)
            link_mem[i] = (i + 1 < POOL_MAX) ? IDX_W'(i + 1) : '0;
        head_idx = '0;
        head_ok  = 1'b1;
        free_cnt = pool_size;
    endfunction

    function automatic t_pool_reply apply_request(logic op, logic [IDX_W-1:0] idx);
        t_pool_reply r;
        r        = '0;
        r.status = fla_pkg::ST_OK;
        if (op == fla_pkg::OP_ALLOC) begin
            if (!head_ok) begin
                r.status = fla_pkg::ST_EXHAUSTED;
            end else begin
                r.granted_index = head_idx;
                head_idx = link_mem[head_idx];
                if (free_cnt > 0)
                    free_cnt--;
                if (free_cnt == 0)
                    head_ok = 1'b0;
            end
        end else if (idx >= pool_size) begin
            r.status = fla_pkg::ST_BAD_INDEX;
        end else begin
            link_mem[idx] = head_idx;
            head_idx      = idx;
            head_ok       = 1'b1;
            // double frees can push the count past the pool size
            if (free_cnt < POOL_MAX)
                free_cnt++;
        end
        r.free_blocks = free_cnt;
        return r;
    endfunction

    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             output t_pool_reply reply);
        int gap;
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.block_index <= idx;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        reply = apply_request(op, idx);
        replies_due.push_back(reply);
        req_count++;
        if (op == fla_pkg::OP_RELEASE && reply.status == fla_pkg::ST_OK)
            release_count++;
        if (reply.status == fla_pkg::ST_EXHAUSTED)
            exhausted_count++;
        else if (reply.status == fla_pkg::ST_BAD_INDEX)
            bad_index_count++;
        else if (op == fla_pkg::OP_ALLOC)
            grant_count++;
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 10);
                if (gap > 0) begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic sender_idle();
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        sender_idle();
        while (replies_due.size() != 0)
            @(posedge i_clk);
        // an allocate may still be loading its new head
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [CNT_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pool_size = clamp_pool_size(value);
        rebuild_list();
        held_blocks.delete();
        size_count++;
    endtask

    // reset pool of full size, LIFO reuse, double free saturating the count
    task automatic test_reset_pool();
        t_pool_reply r;
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(1023), r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(1),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(512),  r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(1023), r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(0),    r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(5),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
    endtask

    // register write of zero: one-block pool, exhaustion and bad indices
    task automatic test_single_block();
        t_pool_reply r;
        write_pool_size('0);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(1023), r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(1),    r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(1023), r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(0),    r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(0),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
    endtask

    // values above the pool limit saturate
    task automatic test_size_saturation();
        t_pool_reply r;
        write_pool_size(CNT_W'(1025));
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
        send_word(fla_pkg::OP_RELEASE, IDX_W'(1023), r);
        write_pool_size(CNT_W'(2047));
        send_word(fla_pkg::OP_ALLOC,   IDX_W'(0),    r);
    endtask

    task automatic test_receiver_holdoff();
        t_pool_reply r;
        logic        op;
        write_pool_size(CNT_W'(16));
        no_gaps     = 1'b1;
        holdoff_len = 400;
        @(posedge i_clk);
        for (int i = 0; i < 24; i++) begin
            op = (i % 3 == 2) ? fla_pkg::OP_RELEASE : fla_pkg::OP_ALLOC;
            send_word(op, IDX_W'(i), r);
        end
        no_gaps = 1'b0;
        sender_idle();
    endtask

    // mostly alloc/free pairs on handed-out blocks, plus stray releases
    task automatic run_pool_phase(input logic [CNT_W-1:0] cfg_value, input int n_items,
                                  input int alloc_pct);
        t_pool_reply      r;
        logic             op;
        logic [IDX_W-1:0] idx;
        int               pick;
        int               roll;
        write_pool_size(cfg_value);
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 7) begin
                op  = fla_pkg::OP_RELEASE;
                idx = IDX_W'($urandom_range(0, POOL_MAX - 1));
            end else if (roll < 11) begin
                op  = fla_pkg::OP_RELEASE;
                idx = IDX_W'($urandom_range(0, pool_size - 1));
            end else if (held_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
                op  = fla_pkg::OP_ALLOC;
                idx = IDX_W'($urandom());
            end else begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                op   = fla_pkg::OP_RELEASE;
                idx  = IDX_W'(held_blocks[pick]);
                held_blocks.delete(pick);
            end
            send_word(op, idx, r);
            if (op == fla_pkg::OP_ALLOC && r.status == fla_pkg::ST_OK)
                held_blocks.push_back(int'(r.granted_index));
        end
    endtask

    // response ready: changing stall patterns plus an optional long hold-off
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_len != 0) begin
                hold_left   = holdoff_len;
                holdoff_len = 0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= (mode_left % 3 == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_pool_reply want;
        t_pool_reply got;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.granted_index = rsp_if.granted_index;
            got.status        = rsp_if.status;
            got.free_blocks   = rsp_if.free_blocks;
            if (replies_due.size() == 0) begin
                fail_count++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("unexpected response word: granted %0d status %0d free %0d",
                             got.granted_index, got.status, got.free_blocks);
                end
            end else begin
                want = replies_due.pop_front();
                if (got.granted_index !== want.granted_index || got.status !== want.status
                        || got.free_blocks !== want.free_blocks) begin
                    fail_count++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("mismatch (exp/got): granted %0d/%0d status %0d/%0d",
                                 want.granted_index, got.granted_index,
                                 want.status, got.status);
                        $display("  free %0d/%0d", want.free_blocks, got.free_blocks);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
                || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= fla_pkg::OP_ALLOC;
        req_if.block_index <= '0;
        pool_size = CNT_W'(POOL_MAX);
        rebuild_list();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_pool();
        test_single_block();
        test_size_saturation();
        test_receiver_holdoff();
        run_pool_phase(CNT_W'(1),    60,  50);
        run_pool_phase(CNT_W'(2),    120, 55);
        run_pool_phase(CNT_W'(7),    250, 50);
        run_pool_phase(CNT_W'(37),   300, 60);
        run_pool_phase(CNT_W'(2047), 300, 70);
        run_pool_phase(CNT_W'(1000), 200, 55);
        run_pool_phase(CNT_W'(16),   370, 45);

        wait_drained();
        repeat (8) @(posedge i_clk);
        fail_count += replies_due.size();
        $display("Covered %0d requests over %0d pool sizes: %0d grants, %0d releases taken,",
                 req_count, size_count + 1, grant_count, release_count);
        $display("  %0d allocates on an empty pool, %0d releases rejected for a bad index.",
                 exhausted_count, bad_index_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### free_list_block_allocator.f
hw/rtl/fla_pkg.sv
hw/rtl/fla_if.sv
hw/rtl/fla_ctrl.sv
hw/rtl/fla_datapath.sv
hw/rtl/free_list_block_allocator.sv
sim/free_list_block_allocator_test.sv
